// ----- design/heap_sorter_u32_macros.svh -----
// Assertion macros used by the sorter top level.
`ifndef HEAP_SORTER_U32_MACROS_SVH
`define HEAP_SORTER_U32_MACROS_SVH

`ifndef SYNTHESIS

// Check with the default clock and reset of the module.
`define HSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define HSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define HSU_ASSERT(lbl, prop, msg)
`define HSU_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- design/hsu_pkg.sv -----
// Types shared by the sorter top level and its cells.
package hsu_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               final_res;
        logic               dropped;
    } t_out_item;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_op;

    // Broadcast to every cell in each cycle.
    typedef struct packed {
        t_cell_op           op;
        logic [VALUE_W-1:0] new_value;
    } t_cell_ctrl;

    // Occupancy of a cell and of its lower neighbor.
    typedef struct packed {
        logic here;
        logic prev;
    } t_cell_occ;

endpackage

// ----- design/hsu_cell.sv -----
// One cell of the sorted chain: holds one value, inserts in order or shifts down.
module hsu_cell (
    input  logic                               i_clk,
    input  hsu_pkg::t_cell_ctrl                i_ctrl,
    input  hsu_pkg::t_cell_occ                 i_occ,
    input  logic [hsu_pkg::VALUE_W-1:0]        i_prev_value,
    input  logic [hsu_pkg::VALUE_W-1:0]        i_next_value,
    output logic [hsu_pkg::VALUE_W-1:0]        o_value
);

    logic [hsu_pkg::VALUE_W-1:0] r_value;
    logic [hsu_pkg::VALUE_W-1:0] n_value;
    logic                        w_take_new;
    logic                        w_take_prev;

    // An empty cell counts as larger than any value.
    assign w_take_new  = !i_occ.here || (i_ctrl.new_value < r_value);
    assign w_take_prev = i_occ.prev && (i_ctrl.new_value < i_prev_value);

    always_comb begin
        n_value = r_value;
        unique case (i_ctrl.op)
            hsu_pkg::CELL_INSERT: begin
                priority if (w_take_prev) begin
                    n_value = i_prev_value;
                end else if (w_take_new) begin
                    n_value = i_ctrl.new_value;
                end else begin
                    n_value = r_value;
                end
            end
            hsu_pkg::CELL_SHIFT: n_value = i_next_value;
            hsu_pkg::CELL_HOLD:  n_value = r_value;
            default:             n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- design/heap_sorter_u32.sv -----
// Top level of the ascending sorter: cell chain, fill control and output register.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_data  (value, last)
//  out      output     o_out_valid / i_out_stall o_out_data (sorted_value, final_res, dropped)
//
// Each input item is inserted in order into the chain in the cycle it is accepted.
// After the last item, the set drains from cell 0 at one result per cycle while the
// output is not stalled, as the chain shifts one cell toward cell 0 on each result.
// The input stalls while a set drains; the output register parts the two sides.
// Reset is synchronous, active low; the chain needs no clearing, only the fill count and control state.
// Items beyond STORE_DEPTH are discarded and flag every result of their set.
module heap_sorter_u32 #(
    parameter int unsigned STORE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hsu_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hsu_pkg::t_out_item o_out_data
);

`include "heap_sorter_u32_macros.svh"

    localparam int unsigned COUNT_W = $clog2(STORE_DEPTH + 1);

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    t_state             r_state;
    logic [COUNT_W-1:0] r_count;
    logic               r_ovf;
    logic               r_out_valid;
    hsu_pkg::t_out_item r_out;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_insert;
    logic                         w_emit;
    hsu_pkg::t_cell_ctrl          w_ctrl;
    logic [hsu_pkg::VALUE_W-1:0]  w_cell_val [STORE_DEPTH];

    assign o_in_stall = (r_state != ST_LOAD);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == COUNT_W'(STORE_DEPTH));
    assign w_insert   = w_accept && !w_full;
    assign w_emit     = (r_state == ST_DRAIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        w_ctrl.new_value = i_in_data.value;
        priority if (w_insert) begin
            w_ctrl.op = hsu_pkg::CELL_INSERT;
        end else if (w_emit) begin
            w_ctrl.op = hsu_pkg::CELL_SHIFT;
        end else begin
            w_ctrl.op = hsu_pkg::CELL_HOLD;
        end
    end

    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        hsu_pkg::t_cell_occ          w_occ;
        logic [hsu_pkg::VALUE_W-1:0] w_prev;
        logic [hsu_pkg::VALUE_W-1:0] w_next;

        assign w_occ.here = (COUNT_W'(g) < r_count);
        if (g == 0) begin : g_first
            assign w_occ.prev = 1'b0;
            assign w_prev     = '0;
        end else begin : g_mid
            assign w_occ.prev = (COUNT_W'(g - 1) < r_count);
            assign w_prev     = w_cell_val[g-1];
        end
        if (g == STORE_DEPTH - 1) begin : g_tail
            assign w_next = w_cell_val[g];
        end else begin : g_body
            assign w_next = w_cell_val[g+1];
        end

        hsu_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occ        (w_occ),
            .i_prev_value (w_prev),
            .i_next_value (w_next),
            .o_value      (w_cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        // Payload: take the head of the chain on each emitted result.
        if (w_emit) begin
            r_out.sorted_value <= w_cell_val[0];
            r_out.final_res    <= (r_count == COUNT_W'(1));
            r_out.dropped      <= r_ovf;
        end
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_insert) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                    if (w_accept && w_full) begin
                        r_ovf <= 1'b1;
                    end
                    if (w_accept && i_in_data.last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_emit) begin
                        r_count <= r_count - COUNT_W'(1);
                        if (r_count == COUNT_W'(1)) begin
                            r_state <= ST_LOAD;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
            // Drop the result once transferred unless a new one replaces it.
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `HSU_ASSERT(a_count_in_range, r_count <= COUNT_W'(STORE_DEPTH), "fill count beyond store depth")
    `HSU_ASSERT(a_drain_not_empty, r_state == ST_DRAIN |-> r_count != '0, "draining an empty chain")
    `HSU_ASSERT(a_head_ordered, r_count >= COUNT_W'(2) |-> w_cell_val[0] <= w_cell_val[1], "chain head out of order")
    `HSU_ASSERT(a_final_ends_set, w_emit && r_count == COUNT_W'(1) |=> r_state == ST_LOAD && r_out.final_res, "final result does not close the set")
    `HSU_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid && r_count == '0, "reset leaves state behind")

endmodule
